### src/particle_pool_engine_macros.svh
// ----------------------------------------------------------------------------
// Particle pool engine assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_ENGINE_MACROS_SVH
`define PARTICLE_POOL_ENGINE_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define PPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check the consequent in the cycle after the antecedent
`define PPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ppe_pkg.sv
// ----------------------------------------------------------------------------
// Particle pool engine package
// Widths, codes, slot record and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int IDX_W     = 10;
  localparam int WIDE_W    = 16;
  localparam int POS_W     = 24;
  localparam int VEL_W     = 16;
  localparam int LIFE_W    = 16;
  localparam int COL_W     = 16;
  localparam int DT_W      = 12;
  localparam int CMD_W     = 2;
  localparam int PROD_W    = VEL_W + DT_W + 1;
  localparam int FRAC_SH   = 14;
  localparam int RED_LSB   = 11;
  localparam int GRN_LSB   = 5;
  localparam int RED_W     = 5;
  localparam int GRN_W     = 6;
  localparam int CH_W      = 6;
  localparam int DIV_STEPS = 6;
  localparam int K_W       = 3;
  localparam int REM_W     = CH_W + LIFE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SP_RD, ST_SP_CHK, ST_TK_RD, ST_TK_CALC,
    ST_TK_WR, ST_RD_RD, ST_RD_INIT, ST_RD_DIV
  } state_t;

  typedef enum logic [1:0] {WR_NONE, WR_CLEAR, WR_SPAWN, WR_TICK} wr_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_SPAWN, RES_DROP, RES_ZERO, RES_READ, RES_OOR
  } res_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
    logic [LIFE_W-1:0]       life;
    logic [LIFE_W-1:0]       full;
    logic [COL_W-1:0]        hot;
    logic [COL_W-1:0]        cool;
  } rec_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] addr;
    wr_t               wr;
    logic              load;
    logic              tick_calc;
    logic              div_init;
    logic              div_step;
    res_t              res;
  } ctl_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              oor;
    logic [SLOT_W-1:0] idx;
    logic              life_zero;
  } sts_t;

endpackage

### src/particle_pool_engine.sv
// ----------------------------------------------------------------------------
// Particle pool engine
// Fixed pool of 1024 particle slots: spawn, tick and read commands.
// ----------------------------------------------------------------------------
// After reset the engine zeroes every slot of the memory with busy high. A
// command is taken when start is high and busy low; every command returns
// exactly one result, shown for one cycle with out_valid high, and the
// receiver cannot stall it. The slot memory has a single port: a spawn reads
// and checks one slot at a time, a tick reads, computes and writes back each
// slot in turn, and a read goes through the memory read, the multiply that
// starts the divider, six divider steps and a settle state for the colour
// blend; an out-of-range read or an unknown command returns from dispatch.
// ----------------------------------------------------------------------------
module particle_pool_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ppe_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [ppe_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [ppe_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [ppe_pkg::POS_W-1:0]     in_pos_z,
  input  logic signed [ppe_pkg::VEL_W-1:0]     in_vel_x,
  input  logic signed [ppe_pkg::VEL_W-1:0]     in_vel_y,
  input  logic signed [ppe_pkg::VEL_W-1:0]     in_vel_z,
  input  logic [ppe_pkg::LIFE_W-1:0]           in_lifetime,
  input  logic [ppe_pkg::COL_W-1:0]            in_color_hot,
  input  logic [ppe_pkg::COL_W-1:0]            in_color_cool,
  input  logic [ppe_pkg::DT_W-1:0]             in_delta_time,
  input  logic [ppe_pkg::IDX_W-1:0]            in_slot_index,
  output logic                                 out_valid,
  output logic [ppe_pkg::IDX_W-1:0]            out_slot_used,
  output logic                                 out_dropped,
  output logic                                 out_alive,
  output logic signed [ppe_pkg::POS_W-1:0]     out_x,
  output logic signed [ppe_pkg::POS_W-1:0]     out_y,
  output logic signed [ppe_pkg::POS_W-1:0]     out_z,
  output logic [ppe_pkg::COL_W-1:0]            out_color
);
  import ppe_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  ppe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // slot memory and arithmetic
  ppe_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_vel_z      (in_vel_z),
    .in_lifetime   (in_lifetime),
    .in_color_hot  (in_color_hot),
    .in_color_cool (in_color_cool),
    .in_delta_time (in_delta_time),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_slot_used (out_slot_used),
    .out_dropped   (out_dropped),
    .out_alive     (out_alive),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_color     (out_color)
  );

endmodule

### src/ppe_ctrl.sv
// ----------------------------------------------------------------------------
// Particle pool engine controller
// Sequences the clearing pass, spawn search, tick sweep and slot read.
// ----------------------------------------------------------------------------
`include "particle_pool_engine_macros.svh"

module ppe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ppe_pkg::sts_t sts,
  output ppe_pkg::ctl_t ctl
);
  import ppe_pkg::*;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] addr_r, addr_nxt;
  logic [SLOT_W-1:0] cursor_r, cursor_nxt;
  logic [SLOT_W-1:0] addr_inc;
  logic              cnt_last;

  assign addr_inc = (addr_r == SLOT_W'(SLOTS - 1)) ? '0 : addr_r + 1'b1;
  assign cnt_last = (cnt_r == SLOT_W'(SLOTS - 1));

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      addr_r   <= '0;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      addr_r   <= addr_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    cursor_nxt    = cursor_r;
    busy          = 1'b1;
    ctl           = '0;
    ctl.addr      = addr_r;
    ctl.wr        = WR_NONE;
    ctl.res       = RES_NONE;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.addr = cnt_r;
        ctl.wr   = WR_CLEAR;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_nxt = '0;
        unique case (sts.cmd)
          CMD_SPAWN: begin
            addr_nxt  = cursor_r;
            state_nxt = ST_SP_RD;
          end
          CMD_TICK: begin
            addr_nxt  = '0;
            state_nxt = ST_TK_RD;
          end
          CMD_READ: begin
            if (sts.oor) begin
              ctl.res   = RES_OOR;
              state_nxt = ST_IDLE;
            end else begin
              addr_nxt  = sts.idx;
              state_nxt = ST_RD_RD;
            end
          end
          CMD_NOP: begin
            ctl.res   = RES_ZERO;
            state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SP_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_SP_CHK;
      end
      ST_SP_CHK: begin
        // take the first dead slot, drop after a full lap
        if (sts.life_zero) begin
          ctl.wr     = WR_SPAWN;
          ctl.res    = RES_SPAWN;
          cursor_nxt = addr_inc;
          state_nxt  = ST_IDLE;
        end else if (cnt_last) begin
          ctl.res   = RES_DROP;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          addr_nxt  = addr_inc;
          state_nxt = ST_SP_RD;
        end
      end
      ST_TK_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_TK_CALC;
      end
      ST_TK_CALC: begin
        ctl.tick_calc = 1'b1;
        state_nxt     = ST_TK_WR;
      end
      ST_TK_WR: begin
        ctl.wr = WR_TICK;
        if (cnt_last) begin
          ctl.res   = RES_ZERO;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          addr_nxt  = addr_inc;
          state_nxt = ST_TK_RD;
        end
      end
      ST_RD_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_RD_INIT;
      end
      ST_RD_INIT: begin
        ctl.div_init = 1'b1;
        state_nxt    = ST_RD_DIV;
      end
      ST_RD_DIV: begin
        // run the divider steps, then register the settled blend
        if (cnt_r == SLOT_W'(DIV_STEPS)) begin
          ctl.res   = RES_READ;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ctl.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `PPE_ASSERT_NOW(a_clear_busy, state_r == ST_CLEAR, busy, "accept during clearing pass")
  `PPE_ASSERT_NEXT(a_cursor_adv, state_r == ST_SP_CHK && sts.life_zero,
                   cursor_r == $past(addr_inc), "cursor not moved past filled slot")
  `PPE_ASSERT_NOW(a_div_bound, state_r == ST_RD_DIV, cnt_r <= SLOT_W'(DIV_STEPS),
                  "divider step count overrun")

endmodule

### src/ppe_dpath.sv
// ----------------------------------------------------------------------------
// Particle pool engine datapath
// Slot memory, tick arithmetic, colour blend divider lanes and result register.
// ----------------------------------------------------------------------------
module ppe_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ppe_pkg::ctl_t                        ctl,
  output ppe_pkg::sts_t                        sts,
  input  logic [ppe_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [ppe_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [ppe_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [ppe_pkg::POS_W-1:0]     in_pos_z,
  input  logic signed [ppe_pkg::VEL_W-1:0]     in_vel_x,
  input  logic signed [ppe_pkg::VEL_W-1:0]     in_vel_y,
  input  logic signed [ppe_pkg::VEL_W-1:0]     in_vel_z,
  input  logic [ppe_pkg::LIFE_W-1:0]           in_lifetime,
  input  logic [ppe_pkg::COL_W-1:0]            in_color_hot,
  input  logic [ppe_pkg::COL_W-1:0]            in_color_cool,
  input  logic [ppe_pkg::DT_W-1:0]             in_delta_time,
  input  logic [ppe_pkg::IDX_W-1:0]            in_slot_index,
  output logic                                 out_valid,
  output logic [ppe_pkg::IDX_W-1:0]            out_slot_used,
  output logic                                 out_dropped,
  output logic                                 out_alive,
  output logic signed [ppe_pkg::POS_W-1:0]     out_x,
  output logic signed [ppe_pkg::POS_W-1:0]     out_y,
  output logic signed [ppe_pkg::POS_W-1:0]     out_z,
  output logic [ppe_pkg::COL_W-1:0]            out_color
);
  import ppe_pkg::*;

  localparam logic signed [POS_W+1:0] POS_MAX = (POS_W+2)'(2**(POS_W-1) - 1);
  localparam logic signed [POS_W+1:0] POS_MIN = -(POS_W+2)'(2**(POS_W-1));

  rec_t mem [SLOTS];
  rec_t rdata_r;
  rec_t wdata;

  cmd_t              cmd_r;
  rec_t              in_r;
  logic [DT_W-1:0]   dt_r;
  logic [IDX_W-1:0]  idx_r;
  logic [WIDE_W-1:0] idx_wide;

  logic signed [PROD_W-1:0] prod_r [3];
  logic [LIFE_W-1:0]        life_new_r;

  logic [CH_W-1:0]  ch_a [3];
  logic [CH_W-1:0]  ch_b [3];
  logic [REM_W-1:0] rem_r [3];
  logic [CH_W-1:0]  q_r [3];
  logic             neg_r [3];
  logic [K_W-1:0]   k_r;
  logic [REM_W-1:0] shifted;
  logic [LIFE_W-1:0] elapsed;
  logic [CH_W+1:0]  blend [3];
  logic [COL_W-1:0] color_mix;

  logic              valid_r;
  logic [IDX_W-1:0]  slot_r;
  logic              drop_r, alive_r;
  logic signed [POS_W-1:0] ox_r, oy_r, oz_r;
  logic [COL_W-1:0]  col_r;
  logic [WIDE_W-1:0] addr_wide;

  // move one coordinate by its registered step, truncating toward zero
  function automatic logic signed [POS_W-1:0] advance(
    input logic signed [POS_W-1:0]  p,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] step;
    logic signed [POS_W+1:0]  sum;
    adj  = prod + (prod[PROD_W-1] ? PROD_W'((1 << FRAC_SH) - 1) : '0);
    step = adj >>> FRAC_SH;
    sum  = (POS_W+2)'(p) + step[POS_W+1:0];
    if (sum > POS_MAX) sum = POS_MAX;
    if (sum < POS_MIN) sum = POS_MIN;
    return sum[POS_W-1:0];
  endfunction

  // status
  assign idx_wide      = WIDE_W'(idx_r);
  assign sts.cmd       = cmd_r;
  assign sts.oor       = (idx_wide >= WIDE_W'(SLOTS));
  assign sts.idx       = idx_wide[SLOT_W-1:0];
  assign sts.life_zero = (rdata_r.life == '0);

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r        <= cmd_t'(in_cmd);
      in_r.px      <= in_pos_x;
      in_r.py      <= in_pos_y;
      in_r.pz      <= in_pos_z;
      in_r.vx      <= in_vel_x;
      in_r.vy      <= in_vel_y;
      in_r.vz      <= in_vel_z;
      in_r.life    <= in_lifetime;
      in_r.full    <= in_lifetime;
      in_r.hot     <= in_color_hot;
      in_r.cool    <= in_color_cool;
      dt_r         <= in_delta_time;
      idx_r        <= in_slot_index;
    end
  end

  // write data for the slot memory
  always_comb begin
    wdata = rdata_r;
    unique case (ctl.wr)
      WR_CLEAR: wdata = '0;
      WR_SPAWN: wdata = in_r;
      WR_TICK: begin
        if (rdata_r.life != '0) begin
          wdata.life = life_new_r;
          wdata.px   = advance(rdata_r.px, prod_r[0]);
          wdata.py   = advance(rdata_r.py, prod_r[1]);
          wdata.pz   = advance(rdata_r.pz, prod_r[2]);
        end
      end
      WR_NONE: wdata = rdata_r;
      default: wdata = rdata_r;
    endcase
  end

  // slot memory, one port
  always_ff @(posedge clk) begin
    if (ctl.wr != WR_NONE) mem[ctl.addr] <= wdata;
    if (ctl.rd_en) rdata_r <= mem[ctl.addr];
  end

  // register velocity times tick length and the lowered life
  always_ff @(posedge clk) begin
    if (ctl.tick_calc) begin
      prod_r[0]  <= PROD_W'(rdata_r.vx) * PROD_W'($signed({1'b0, dt_r}));
      prod_r[1]  <= PROD_W'(rdata_r.vy) * PROD_W'($signed({1'b0, dt_r}));
      prod_r[2]  <= PROD_W'(rdata_r.vz) * PROD_W'($signed({1'b0, dt_r}));
      life_new_r <= (rdata_r.life > LIFE_W'(dt_r)) ? rdata_r.life - LIFE_W'(dt_r) : '0;
    end
  end

  // split colours into channels
  always_comb begin
    ch_a[0] = CH_W'(rdata_r.hot[RED_LSB +: RED_W]);
    ch_a[1] = CH_W'(rdata_r.hot[GRN_LSB +: GRN_W]);
    ch_a[2] = CH_W'(rdata_r.hot[RED_W-1:0]);
    ch_b[0] = CH_W'(rdata_r.cool[RED_LSB +: RED_W]);
    ch_b[1] = CH_W'(rdata_r.cool[GRN_LSB +: GRN_W]);
    ch_b[2] = CH_W'(rdata_r.cool[RED_W-1:0]);
  end

  assign elapsed = rdata_r.full - rdata_r.life;
  assign shifted = REM_W'(rdata_r.full) << k_r;

  // blend lanes: restoring division of |cool-hot|*elapsed by full life
  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      k_r <= K_W'(DIV_STEPS - 1);
    end else if (ctl.div_step) begin
      k_r <= k_r - 1'b1;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [CH_W+1:0] diff;
    logic [CH_W+1:0] mag;
    assign diff = {2'b00, ch_b[c]} - {2'b00, ch_a[c]};
    assign mag  = diff[CH_W+1] ? -diff : diff;

    always_ff @(posedge clk) begin
      if (ctl.div_init) begin
        neg_r[c] <= diff[CH_W+1];
        rem_r[c] <= REM_W'(mag[CH_W-1:0]) * REM_W'(elapsed);
        q_r[c]   <= '0;
      end else if (ctl.div_step) begin
        if (rem_r[c] >= shifted) begin
          rem_r[c]    <= rem_r[c] - shifted;
          q_r[c][k_r] <= 1'b1;
        end
      end
    end

    assign blend[c] = {2'b00, ch_a[c]} +
                      (neg_r[c] ? -{2'b00, q_r[c]} : {2'b00, q_r[c]});
  end

  // pack blended channels, cool colour for dead or zero-length life
  always_comb begin
    if (rdata_r.life == '0 || rdata_r.full == '0) begin
      color_mix = rdata_r.cool;
    end else begin
      color_mix = {blend[0][RED_W-1:0], blend[1][GRN_W-1:0], blend[2][RED_W-1:0]};
    end
  end

  assign addr_wide = WIDE_W'(ctl.addr);

  // result register, one strobe per command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctl.res != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res != RES_NONE) begin
      slot_r  <= '0;
      drop_r  <= 1'b0;
      alive_r <= 1'b0;
      ox_r    <= '0;
      oy_r    <= '0;
      oz_r    <= '0;
      col_r   <= '0;
      priority case (ctl.res)
        RES_SPAWN: slot_r <= addr_wide[IDX_W-1:0];
        RES_DROP:  drop_r <= 1'b1;
        RES_OOR:   slot_r <= idx_r;
        RES_READ: begin
          slot_r  <= idx_r;
          alive_r <= (rdata_r.life != '0);
          ox_r    <= rdata_r.px;
          oy_r    <= rdata_r.py;
          oz_r    <= rdata_r.pz;
          col_r   <= color_mix;
        end
        default: slot_r <= '0;
      endcase
    end
  end

  assign out_valid     = valid_r;
  assign out_slot_used = slot_r;
  assign out_dropped   = drop_r;
  assign out_alive     = alive_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_color     = col_r;

endmodule
